[rtl/luma_bucket_knob_slew_tuner_assert.svh]
// ----------------------------------------------------------------------------
// Assertion macros for the luma bucket knob slew tuner
// Shared concurrent assertion forms, all clocked and reset-qualified.
// ----------------------------------------------------------------------------
`ifndef LUMA_BUCKET_KNOB_SLEW_TUNER_ASSERT_SVH
`define LUMA_BUCKET_KNOB_SLEW_TUNER_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define LBKST_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("lbkst assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define LBKST_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("lbkst assertion failed");

`endif

[rtl/lbkst_pkg.sv]
// ----------------------------------------------------------------------------
// lbkst_pkg
// Types, codes and constant tables of the luma bucket knob slew tuner.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package lbkst_pkg;

    localparam int LEVEL_W    = 7;
    localparam int BUCKET_W   = 3;
    localparam int NUM_BUCKET = 5;
    localparam int NUM_EDGE   = 4;
    localparam int NUM_KNOB   = 3;
    localparam int CFG_IDX_W  = 2;

    localparam int SLEW_STEP_MAX = 5;
    localparam int HYSTERESIS    = 6;
    localparam int CENTER        = 50;
    localparam int LEVEL_MAX     = 100;

    typedef logic [LEVEL_W-1:0]   t_level;
    typedef logic [BUCKET_W-1:0]  t_bucket;
    typedef logic [7:0]           t_luma;
    typedef logic [1:0]           t_aggr;
    typedef logic [CFG_IDX_W-1:0] t_cfg_idx;

    // Aggressiveness codes; the spare code scales by one and a half like boost.
    localparam t_aggr AGGR_HALF  = 2'd0;
    localparam t_aggr AGGR_KEEP  = 2'd1;
    localparam t_aggr AGGR_BOOST = 2'd2;
    localparam t_aggr AGGR_SPARE = 2'd3;

    // Configuration register indexes.
    localparam t_cfg_idx CFG_AGGR           = 2'd0;
    localparam t_cfg_idx CFG_SEED_CONTRAST  = 2'd1;
    localparam t_cfg_idx CFG_SEED_SHARPNESS = 2'd2;
    localparam t_cfg_idx CFG_SEED_WDR       = 2'd3;

    // Knob order within a table row and within the level store.
    localparam int KNOB_CONTRAST  = 0;
    localparam int KNOB_SHARPNESS = 1;
    localparam int KNOB_WDR       = 2;

    localparam t_luma LUMA_EDGE [NUM_EDGE] = '{8'd30, 8'd80, 8'd180, 8'd220};

    localparam t_level KNOB_TABLE [NUM_BUCKET][NUM_KNOB] = '{
        '{7'd52, 7'd48, 7'd30},
        '{7'd51, 7'd50, 7'd35},
        '{7'd50, 7'd52, 7'd40},
        '{7'd49, 7'd54, 7'd45},
        '{7'd48, 7'd50, 7'd50}
    };

    typedef struct packed {
        logic  stats_valid;
        t_luma y_mean;
    } t_in_item;

    typedef struct packed {
        t_level  contrast_out;
        t_level  sharpness_out;
        t_level  wdr_out;
        t_bucket bucket_out;
        logic    contrast_write;
        logic    sharpness_write;
        logic    wdr_write;
    } t_out_item;

    typedef struct packed {
        t_cfg_idx reg_index;
        t_level   wdata;
    } t_cfg_wr;

endpackage

`default_nettype wire

[rtl/lbkst_if.sv]
// ----------------------------------------------------------------------------
// lbkst interfaces
// Valid/ready channels for input items, result items and register writes.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface lbkst_in_if;
    logic                valid;
    logic                ready;
    lbkst_pkg::t_in_item data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface lbkst_out_if;
    logic                 valid;
    logic                 ready;
    lbkst_pkg::t_out_item data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface lbkst_cfg_if;
    logic               valid;
    logic               ready;
    lbkst_pkg::t_cfg_wr data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

[rtl/luma_bucket_knob_slew_tuner.sv]
// ----------------------------------------------------------------------------
// luma_bucket_knob_slew_tuner
// Picks a brightness bucket from mean luma and slews three image knobs.
// ----------------------------------------------------------------------------
// A user's view: every input transaction yields exactly one result
// transaction. The whole update is computed in the cycle the input is taken
// and lands in the result register, or in the skid register while an older
// result waits, and the block takes one transaction per cycle for as long
// as results are drained. Behind the result register sits a one-entry skid
// register, so a new input is still taken while one finished result waits;
// input ready falls only when both hold results. The configuration channel is
// always ready, and registers should only be written while no transaction is
// in flight. The first input transaction after reset loads the knob levels
// from the seed registers (saturated to 100) whether or not its statistics
// are valid.
`timescale 1ns / 1ps
`default_nettype none

module luma_bucket_knob_slew_tuner (
    input  wire        i_clk,
    input  wire        i_rst_n,
    lbkst_in_if.sink   i_in,
    lbkst_cfg_if.sink  i_cfg,
    lbkst_out_if.source o_out
);

`include "luma_bucket_knob_slew_tuner_assert.svh"

    // ------------------------------------------------------------------
    // Helper functions.
    // ------------------------------------------------------------------

    // Saturates a seed to the legal level range.
    function automatic lbkst_pkg::t_level sat_seed(input lbkst_pkg::t_level s);
        if (s > lbkst_pkg::t_level'(lbkst_pkg::LEVEL_MAX)) begin
            return lbkst_pkg::t_level'(lbkst_pkg::LEVEL_MAX);
        end
        return s;
    endfunction

    // Scales a target's offset from the centre, truncating toward zero, then
    // clamps the result to the level range.
    function automatic lbkst_pkg::t_level shape_target(input lbkst_pkg::t_level t,
                                                      input lbkst_pkg::t_aggr  aggr);
        logic signed [9:0] d;
        logic signed [9:0] v;
        d = $signed({3'b000, t}) - 10'sd50;
        case (aggr)
            lbkst_pkg::AGGR_HALF: d = d / 10'sd2;
            lbkst_pkg::AGGR_KEEP: d = d;
            default:              d = (d + (d <<< 1)) / 10'sd2;
        endcase
        v = d + 10'(lbkst_pkg::CENTER);
        if (v < 10'sd0) begin
            v = 10'sd0;
        end else if (v > 10'(lbkst_pkg::LEVEL_MAX)) begin
            v = 10'(lbkst_pkg::LEVEL_MAX);
        end
        return v[lbkst_pkg::LEVEL_W-1:0];
    endfunction

    // Moves a level toward its target by no more than the step limit.
    function automatic lbkst_pkg::t_level slew(input lbkst_pkg::t_level cur,
                                              input lbkst_pkg::t_level tgt);
        logic signed [8:0] d;
        d = $signed({2'b00, tgt}) - $signed({2'b00, cur});
        if (d > 9'(lbkst_pkg::SLEW_STEP_MAX)) begin
            return cur + lbkst_pkg::t_level'(lbkst_pkg::SLEW_STEP_MAX);
        end else if (d < -9'(lbkst_pkg::SLEW_STEP_MAX)) begin
            return cur - lbkst_pkg::t_level'(lbkst_pkg::SLEW_STEP_MAX);
        end
        return tgt;
    endfunction

    // Bucket from the thresholds alone.
    function automatic lbkst_pkg::t_bucket plain_bucket(input lbkst_pkg::t_luma y);
        if (y < lbkst_pkg::LUMA_EDGE[0]) begin
            return 3'd0;
        end else if (y < lbkst_pkg::LUMA_EDGE[1]) begin
            return 3'd1;
        end else if (y < lbkst_pkg::LUMA_EDGE[2]) begin
            return 3'd2;
        end else if (y < lbkst_pkg::LUMA_EDGE[3]) begin
            return 3'd3;
        end
        return 3'd4;
    endfunction

    // ------------------------------------------------------------------
    // Configuration registers. Every write is taken at once.
    // ------------------------------------------------------------------
    lbkst_pkg::t_aggr  r_aggr;
    lbkst_pkg::t_level r_seed [lbkst_pkg::NUM_KNOB];

    wire cfg_fire = i_cfg.valid && i_cfg.ready;

    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_aggr    <= lbkst_pkg::AGGR_KEEP;
            r_seed[0] <= lbkst_pkg::t_level'(lbkst_pkg::CENTER);
            r_seed[1] <= lbkst_pkg::t_level'(lbkst_pkg::CENTER);
            r_seed[2] <= lbkst_pkg::t_level'(lbkst_pkg::CENTER);
        end else if (cfg_fire) begin
            unique case (i_cfg.data.reg_index)
                lbkst_pkg::CFG_AGGR:
                    r_aggr <= i_cfg.data.wdata[1:0];
                lbkst_pkg::CFG_SEED_CONTRAST:
                    r_seed[lbkst_pkg::KNOB_CONTRAST] <= i_cfg.data.wdata;
                lbkst_pkg::CFG_SEED_SHARPNESS:
                    r_seed[lbkst_pkg::KNOB_SHARPNESS] <= i_cfg.data.wdata;
                lbkst_pkg::CFG_SEED_WDR:
                    r_seed[lbkst_pkg::KNOB_WDR] <= i_cfg.data.wdata;
                default: ;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Tuner state and the single-pass update.
    // ------------------------------------------------------------------
    lbkst_pkg::t_bucket   r_bucket;
    logic                 r_bucket_known;
    logic                 r_started;
    lbkst_pkg::t_level    r_level [lbkst_pkg::NUM_KNOB];

    lbkst_pkg::t_level    cur     [lbkst_pkg::NUM_KNOB];
    lbkst_pkg::t_level    n_level [lbkst_pkg::NUM_KNOB];
    logic                 knob_wr [lbkst_pkg::NUM_KNOB];
    lbkst_pkg::t_bucket   plain;
    lbkst_pkg::t_bucket   chosen;
    lbkst_pkg::t_bucket   n_bucket;
    lbkst_pkg::t_level    tgt;
    lbkst_pkg::t_level    nv;
    lbkst_pkg::t_out_item new_item;

    logic r_out_valid;
    logic r_skid_valid;
    lbkst_pkg::t_out_item r_out;
    lbkst_pkg::t_out_item r_skid;

    wire in_fire  = i_in.valid && i_in.ready;
    wire out_take = r_out_valid && o_out.ready;

    // With two result slots, input is refused only while the skid slot is full.
    assign i_in.ready = !r_skid_valid;

    always_comb begin
        // Levels in force for this transaction: seeds on the very first one.
        for (int k = 0; k < lbkst_pkg::NUM_KNOB; k++) begin
            cur[k] = r_started ? r_level[k] : sat_seed(r_seed[k]);
        end

        // Hysteresis: leaving the current bucket needs the luma to clear the
        // boundary by the hysteresis margin, in either direction.
        plain  = plain_bucket(i_in.data.y_mean);
        chosen = plain;
        if (r_bucket_known && plain != r_bucket) begin
            if (plain > r_bucket) begin
                if ({1'b0, i_in.data.y_mean} <
                    {1'b0, lbkst_pkg::LUMA_EDGE[r_bucket[1:0]]}
                        + 9'(lbkst_pkg::HYSTERESIS)) begin
                    chosen = r_bucket;
                end
            end else begin
                if ({1'b0, i_in.data.y_mean} + 9'(lbkst_pkg::HYSTERESIS) >
                    {1'b0, lbkst_pkg::LUMA_EDGE[plain[1:0]]}) begin
                    chosen = r_bucket;
                end
            end
        end

        n_bucket = i_in.data.stats_valid ? chosen : r_bucket;

        tgt = '0;
        nv  = '0;
        for (int k = 0; k < lbkst_pkg::NUM_KNOB; k++) begin
            tgt = shape_target(lbkst_pkg::KNOB_TABLE[chosen][k], r_aggr);
            nv  = slew(cur[k], tgt);
            if (i_in.data.stats_valid) begin
                n_level[k] = nv;
                knob_wr[k] = (nv != cur[k]);
            end else begin
                n_level[k] = cur[k];
                knob_wr[k] = 1'b0;
            end
        end

        new_item.contrast_out    = n_level[lbkst_pkg::KNOB_CONTRAST];
        new_item.sharpness_out   = n_level[lbkst_pkg::KNOB_SHARPNESS];
        new_item.wdr_out         = n_level[lbkst_pkg::KNOB_WDR];
        new_item.bucket_out      = n_bucket;
        new_item.contrast_write  = knob_wr[lbkst_pkg::KNOB_CONTRAST];
        new_item.sharpness_write = knob_wr[lbkst_pkg::KNOB_SHARPNESS];
        new_item.wdr_write       = knob_wr[lbkst_pkg::KNOB_WDR];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bucket       <= '0;
            r_bucket_known <= 1'b0;
            r_started      <= 1'b0;
            for (int k = 0; k < lbkst_pkg::NUM_KNOB; k++) begin
                r_level[k] <= lbkst_pkg::t_level'(lbkst_pkg::CENTER);
            end
        end else if (in_fire) begin
            r_started <= 1'b1;
            r_bucket  <= n_bucket;
            if (i_in.data.stats_valid) begin
                r_bucket_known <= 1'b1;
            end
            for (int k = 0; k < lbkst_pkg::NUM_KNOB; k++) begin
                r_level[k] <= n_level[k];
            end
        end
    end

    // ------------------------------------------------------------------
    // Result register with a skid register behind it.
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (!r_out_valid || out_take) begin
            if (r_skid_valid) begin
                r_out_valid  <= 1'b1;
                r_skid_valid <= 1'b0;
            end else begin
                r_out_valid  <= in_fire;
            end
        end else if (in_fire) begin
            r_skid_valid <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!r_out_valid || out_take) begin
            if (r_skid_valid) begin
                r_out <= r_skid;
            end else if (in_fire) begin
                r_out <= new_item;
            end
        end else if (in_fire) begin
            r_skid <= new_item;
        end
    end

    assign o_out.valid = r_out_valid;
    assign o_out.data  = r_out;

    // ------------------------------------------------------------------
    // Assertions.
    // ------------------------------------------------------------------
    `LBKST_ASSERT_NOW(a_skid_behind_out, i_clk, i_rst_n, r_skid_valid, r_out_valid)
    `LBKST_ASSERT_NOW(a_levels_in_range, i_clk, i_rst_n, 1'b1,
        r_level[0] <= 7'd100 && r_level[1] <= 7'd100 && r_level[2] <= 7'd100)
    `LBKST_ASSERT_NEXT(a_started_after_item, i_clk, i_rst_n, in_fire, r_started)
    `LBKST_ASSERT_NEXT(a_contrast_slew_bound, i_clk, i_rst_n, in_fire,
        r_level[0] <= $past(cur[0]) + lbkst_pkg::t_level'(lbkst_pkg::SLEW_STEP_MAX) && r_level[0] + lbkst_pkg::t_level'(lbkst_pkg::SLEW_STEP_MAX) >= $past(cur[0]))

endmodule

`default_nettype wire
